// ===== hw/rtl/sstrr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sstrr_pkg
// Types, character codes and the segment table shared by the seven-segment
// text row renderer.
// ----------------------------------------------------------------------------
package sstrr_pkg;

	localparam int SCALE_W     = 4;
	localparam int DIGIT_W     = 4;
	localparam int ROW_W       = 6;
	localparam int CHAR_W      = 7;
	localparam int COL_W       = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd2;

	localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
	localparam logic [CHAR_W-1:0] CH_DASH  = 7'd45;
	localparam logic [CHAR_W-1:0] CH_BAR   = 7'd124;

	// Bit positions in a segment set.
	localparam int SEG_TOP = 0;
	localparam int SEG_UR  = 1;
	localparam int SEG_UL  = 2;
	localparam int SEG_MID = 3;
	localparam int SEG_LR  = 4;
	localparam int SEG_LL  = 5;
	localparam int SEG_BOT = 6;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic [ROW_W-1:0]   row;
		logic               line_end;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last;
		logic              line_done;
	} out_item_t;

	// One classified glyph row: which strokes are drawn in this row.
	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic               dash_on;
		logic               left_on;
		logic               right_on;
		logic               line_end;
	} glyph_row_t;

	typedef struct packed {
		logic       push;
		glyph_row_t data;
	} queue_wr_t;

	function automatic logic [6:0] seg_lookup(input logic [DIGIT_W-1:0] digit);
		logic [6:0] segs;
		unique case (digit)
			4'd0:    segs = 7'b1110111;
			4'd1:    segs = 7'b0010010;
			4'd2:    segs = 7'b1101011;
			4'd3:    segs = 7'b1011011;
			4'd4:    segs = 7'b0011110;
			4'd5:    segs = 7'b1011101;
			4'd6:    segs = 7'b1111101;
			4'd7:    segs = 7'b0010011;
			4'd8:    segs = 7'b1111111;
			4'd9:    segs = 7'b1011111;
			default: segs = 7'b0000000;
		endcase
		return segs;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/seven_segment_text_row_render_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_text_row_render_core
// Renders one text row of a seven-segment style decimal digit glyph.
// ----------------------------------------------------------------------------
// Each digit transaction produces scale+3 character transactions (3 to 18),
// one per cycle while out_stall is low: left column, scale dash columns,
// right column and a blank spacing column; the final one carries last, and
// line_done as well when line_end was set. The column counter of the
// character sequencer steps through the columns of each digit; a front
// register and a two-entry queue take new digits while a row is still being
// emitted. The scale register is written over the cfg channel, which is
// always ready, and must only be written while no digit is in flight.
// ----------------------------------------------------------------------------
module seven_segment_text_row_render_core import sstrr_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [SCALE_W-1:0] cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire in_item_t           in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output out_item_t               out_data
);

	queue_wr_t  q_wr;
	logic       q_full;
	logic       q_valid;
	glyph_row_t q_data;
	logic       q_pop;

	sstrr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_wr      (q_wr),
		.q_full    (q_full)
	);

	sstrr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_wr    (q_wr),
		.q_full  (q_full),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop)
	);

	sstrr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/sstrr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sstrr_front
// Holds the scale register, accepts digit transactions and classifies the
// requested row into the strokes it draws, then hands it to the queue.
// ----------------------------------------------------------------------------
module sstrr_front import sstrr_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [SCALE_W-1:0] cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire in_item_t           in_data,
	output queue_wr_t               q_wr,
	input  wire logic               q_full
);

	logic [SCALE_W-1:0] scale_q;
	logic               valid_s1;
	glyph_row_t         row_s1;
	glyph_row_t         row_class;
	logic [6:0]         segs;
	logic [COL_W-1:0]   sc;
	logic [ROW_W-1:0]   r;
	logic               accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_valid) begin
			scale_q <= cfg_data;
		end
	end

	assign segs = seg_lookup(in_data.digit);
	assign sc   = {1'b0, scale_q};
	assign r    = in_data.row;

	// Band order matters: with a scale of zero the upper and lower vertical
	// bands are empty and the middle and bottom bands fall on rows one and two.
	always_comb begin
		row_class          = '0;
		row_class.scale    = scale_q;
		row_class.line_end = in_data.line_end;
		priority if (r == '0) begin
			row_class.dash_on = segs[SEG_TOP];
		end else if (r <= ROW_W'(sc)) begin
			row_class.left_on  = segs[SEG_UL];
			row_class.right_on = segs[SEG_UR];
		end else if (r == ROW_W'(sc + 5'd1)) begin
			row_class.dash_on = segs[SEG_MID];
		end else if (r <= ROW_W'({sc, 1'b1})) begin
			row_class.left_on  = segs[SEG_LL];
			row_class.right_on = segs[SEG_LR];
		end else if (r == ROW_W'({sc, 1'b0} + 6'd2)) begin
			row_class.dash_on = segs[SEG_BOT];
		end else begin
			row_class.dash_on = 1'b0;
		end
	end

	assign in_stall  = valid_s1 && q_full;
	assign accept    = in_valid && !in_stall;
	assign q_wr.push = valid_s1 && !q_full;
	assign q_wr.data = row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_wr.push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1 <= row_class;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sstrr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sstrr_queue
// Short first-in first-out queue of classified glyph rows between the
// front end and the character sequencer.
// ----------------------------------------------------------------------------
module sstrr_queue import sstrr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire queue_wr_t q_wr,
	output logic           q_full,
	output logic           q_valid,
	output glyph_row_t     q_data,
	input  wire logic      q_pop
);

	glyph_row_t        entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign q_full  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign q_valid = count_q != '0;
	assign q_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W+1)'(q_wr.push) - (QPTR_W+1)'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			entry_q[wr_ptr_q] <= q_wr.data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_wr.push)
		else $error("queue written while full");

endmodule
`default_nettype wire

// ===== hw/rtl/sstrr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sstrr_back
// Character sequencer: walks the scale+3 columns of one glyph row, one
// character per cycle while out_stall allows, into a registered output stage.
// ----------------------------------------------------------------------------
module sstrr_back import sstrr_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_valid,
	input  wire glyph_row_t q_data,
	output logic        q_pop,
	output logic        out_valid,
	input  wire logic   out_stall,
	output out_item_t   out_data
);

	glyph_row_t        cur_q;
	logic              active_q;
	logic [COL_W-1:0]  col_q;
	logic              out_valid_q;
	out_item_t         out_data_q;
	logic [COL_W-1:0]  sc;
	logic              advance;
	logic              fin;
	out_item_t         next_out;

	assign sc      = {1'b0, cur_q.scale};
	assign advance = active_q && (!out_valid_q || !out_stall);
	assign fin     = col_q == sc + 5'd2;
	assign q_pop   = q_valid && (!active_q || (advance && fin));

	always_comb begin
		next_out.last      = fin;
		next_out.line_done = fin && cur_q.line_end;
		priority if (col_q == '0) begin
			next_out.char_code = cur_q.left_on ? CH_BAR : CH_SPACE;
		end else if (col_q <= sc) begin
			next_out.char_code = cur_q.dash_on ? CH_DASH : CH_SPACE;
		end else if (col_q == sc + 5'd1) begin
			next_out.char_code = cur_q.right_on ? CH_BAR : CH_SPACE;
		end else begin
			next_out.char_code = CH_SPACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= advance;
			end
			if (q_pop) begin
				active_q <= 1'b1;
				col_q    <= '0;
			end else if (advance && fin) begin
				active_q <= 1'b0;
			end else if (advance) begin
				col_q <= col_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (advance) begin
			out_data_q <= next_out;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> col_q <= sc + 5'd2)
		else $error("column counter ran past the end of the row");

	a_line_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.line_done |-> out_data_q.last)
		else $error("line_done without last");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid && (!active_q || fin))
		else $error("queue popped while a row is still in progress");

endmodule
`default_nettype wire

// ===== sim/sstrr_row_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sstrr_row_checker
// Watches the configuration, digit and character channels of the seven-segment
// text row renderer. It predicts the characters of each accepted digit and
// compares every accepted character transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module sstrr_row_checker import sstrr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [SCALE_W-1:0] cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  in_item_t           in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  out_item_t          out_data,
	output int                 chars_pending,
	output int                 fail_count
);

	logic [SCALE_W-1:0] glyph_scale;
	out_item_t          expected_chars[$];
	int                 mismatches;

	function automatic logic [6:0] lit_segments(input logic [DIGIT_W-1:0] d);
		logic [6:0] s;
		s = '0;
		s[SEG_TOP] = d inside {0, 2, 3, 5, 6, 7, 8, 9};
		s[SEG_UR]  = d inside {0, 1, 2, 3, 4, 7, 8, 9};
		s[SEG_UL]  = d inside {0, 4, 5, 6, 8, 9};
		s[SEG_MID] = d inside {2, 3, 4, 5, 6, 8, 9};
		s[SEG_LR]  = d inside {0, 1, 3, 4, 5, 6, 7, 8, 9};
		s[SEG_LL]  = d inside {0, 2, 6, 8};
		s[SEG_BOT] = d inside {0, 2, 3, 5, 6, 8, 9};
		return s;
	endfunction

	function automatic logic [CHAR_W-1:0] glyph_code(input logic [6:0] segs, input int sc,
			input int r, input int c);
		logic dash_col;
		logic left_col;
		logic right_col;
		dash_col  = (c >= 1) && (c <= sc);
		left_col  = (c == 0);
		right_col = (c == sc + 1);
		if (r == 0)
			return (dash_col && segs[SEG_TOP]) ? CH_DASH : CH_SPACE;
		if (r <= sc) begin
			if ((left_col && segs[SEG_UL]) || (right_col && segs[SEG_UR]))
				return CH_BAR;
			return CH_SPACE;
		end
		if (r == sc + 1)
			return (dash_col && segs[SEG_MID]) ? CH_DASH : CH_SPACE;
		if (r <= 2 * sc + 1) begin
			if ((left_col && segs[SEG_LL]) || (right_col && segs[SEG_LR]))
				return CH_BAR;
			return CH_SPACE;
		end
		if (r == 2 * sc + 2)
			return (dash_col && segs[SEG_BOT]) ? CH_DASH : CH_SPACE;
		return CH_SPACE;
	endfunction

	// Queues the characters of one digit row, left column first.
	task automatic render_row(input in_item_t item);
		int         sc;
		int         total;
		logic [6:0] segs;
		out_item_t  ch;
		sc    = int'(glyph_scale);
		total = sc + 3;
		segs  = lit_segments(item.digit);
		for (int c = 0; c < total; c++) begin
			ch.char_code = glyph_code(segs, sc, int'(item.row), c);
			ch.last      = (c == total - 1);
			ch.line_done = (c == total - 1) && item.line_end;
			expected_chars.push_back(ch);
		end
	endtask

	task automatic check_char(input out_item_t got);
		out_item_t want;
		if (expected_chars.size() == 0) begin
			if (mismatches < 10)
				$display("%0t: unexpected character transaction, char %0d last %0b done %0b",
					$time, got.char_code, got.last, got.line_done);
			mismatches++;
			return;
		end
		want = expected_chars.pop_front();
		if (got.char_code !== want.char_code || got.last !== want.last ||
				got.line_done !== want.line_done) begin
			if (mismatches < 10)
				$display("%0t: expected char %0d last %0b done %0b, got char %0d last %0b done %0b",
					$time, want.char_code, want.last, want.line_done,
					got.char_code, got.last, got.line_done);
			mismatches++;
		end
	endtask

	// The digit is taken before the character so that a same-edge result would still match.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_scale = SCALE_RESET;
			expected_chars.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				glyph_scale = cfg_data;
			if (in_valid && !in_stall)
				render_row(in_data);
			if (out_valid && !out_stall)
				check_char(out_data);
		end
		chars_pending = expected_chars.size();
		fail_count    = mismatches;
	end

endmodule

// ===== sim/tb_seven_segment_text_row_render_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_seven_segment_text_row_render_core
// Drives digit rows into the seven-segment text row renderer at several glyph
// scales, with random gaps on the digit side and random stalls on the
// character side; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_seven_segment_text_row_render_core;
	import sstrr_pkg::*;

	localparam int CYCLE_LIMIT = 300000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic [SCALE_W-1:0] cfg_data = '0;
	logic               in_valid = 1'b0;
	in_item_t           in_data = '0;
	logic               out_stall = 1'b0;
	logic               cfg_ready;
	logic               in_stall;
	logic               out_valid;
	out_item_t          out_data;
	int                 chars_pending;
	int                 fail_count;
	int                 cycles = 0;
	logic               calm = 1'b0;
	logic [SCALE_W-1:0] cur_scale = SCALE_RESET;

	always #5 clk = ~clk;

	seven_segment_text_row_render_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	sstrr_row_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.chars_pending (chars_pending),
		.fail_count    (fail_count)
	);

	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 12);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Called and returning at a falling edge.
	task automatic send_digit(input logic [DIGIT_W-1:0] d, input logic [ROW_W-1:0] r,
			input logic e);
		in_item_t item;
		item.digit    = d;
		item.row      = r;
		item.line_end = e;
		while (!calm && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_rows();
		in_valid <= 1'b0;
		while (chars_pending != 0)
			@(negedge clk);
	endtask

	task automatic write_scale(input logic [SCALE_W-1:0] s);
		drain_rows();
		cfg_valid <= 1'b1;
		cfg_data  <= s;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_scale = s;
	endtask

	// Mostly real digits on rows inside the glyph, with some noise beyond both.
	task automatic random_digit();
		logic [DIGIT_W-1:0] d;
		logic [ROW_W-1:0]   r;
		int                 reach;
		reach = 2 * int'(cur_scale) + 2;
		if ($urandom_range(9) == 0)
			d = DIGIT_W'($urandom_range(15, 10));
		else
			d = DIGIT_W'($urandom_range(9));
		if ($urandom_range(6) == 0)
			r = ROW_W'($urandom_range(63));
		else
			r = ROW_W'($urandom_range(reach));
		send_digit(d, r, 1'($urandom_range(1)));
	endtask

	initial begin
		logic [SCALE_W-1:0] phase_scale[6];
		phase_scale = '{4'd1, 4'd15, 4'd0, 4'd7, 4'd3, SCALE_W'($urandom_range(15))};

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Every band of the full glyph at the reset scale, then each digit.
		for (int r = 0; r < 8; r++)
			send_digit(4'd8, ROW_W'(r), 1'b0);
		for (int d = 0; d < 10; d++)
			if (d != 8)
				send_digit(DIGIT_W'(d), ROW_W'(d % 7), 1'(d % 2));
		send_digit(4'd10, 6'd1, 1'b1);
		send_digit(4'd15, 6'd63, 1'b1);

		// A zero scale folds the glyph to three rows and three columns.
		write_scale(4'd0);
		for (int r = 0; r < 4; r++)
			send_digit(4'd8, ROW_W'(r), 1'b1);
		write_scale(4'd15);
		send_digit(4'd0, 6'd16, 1'b0);
		send_digit(4'd0, 6'd32, 1'b1);

		for (int p = 0; p < 6; p++) begin
			write_scale(phase_scale[p]);
			calm = (p == 1);
			for (int i = 0; i < 42; i++) begin
				if (p == 3 && i == 20)
					drain_rows();
				random_digit();
			end
		end
		calm = 1'b0;

		drain_rows();
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
